>>> hw/rtl/bbfse_pkg.sv
package bbfse_pkg;

	// default widths of the top level parameters
	localparam int COORD_WIDTH_DEF = 32;
	localparam int INDEX_WIDTH_DEF = 32;
	localparam int BLOCK_WIDTH_DEF = 16;
	localparam int ROW_WIDTH_DEF   = 16;

	localparam int CMD_W      = 2;
	localparam int KIND_W     = 3;
	localparam int REG_IDX_W  = 3;
	localparam int NUM_SLOTS  = 3;
	localparam int LEVEL_W    = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_RECT   = 2'd0,
		CMD_REPORT = 2'd1,
		CMD_LOAD   = 2'd2
	} cmd_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_INFO  = 3'd0,
		KIND_LEFT  = 3'd1,
		KIND_RIGHT = 3'd2,
		KIND_BOX_X = 3'd3,
		KIND_BOX_Y = 3'd4,
		KIND_BOX_Z = 3'd5
	} kind_t;

	// configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_FILTER_X_LOW  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_FILTER_X_HIGH = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_FILTER_Y_LOW  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_FILTER_Y_HIGH = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_FILTER_Z_LOW  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_FILTER_Z_HIGH = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_EMIT_EDGES    = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_THREE_DIMS    = 3'd7;

	// result buffer load request
	typedef struct packed {
		logic               push;
		logic [LEVEL_W-1:0] count;
	} buf_load_t;

	// result buffer status
	typedef struct packed {
		logic free;
	} buf_stat_t;

endpackage

>>> hw/rtl/bbox_filter_sweep_edge_emitter_top.sv
// bounding box filter with plane-sweep edge output. each input item is a rectangle, a
// report command or an index load (s_axis_tuser). defined rectangles widen a running
// bounding box; with edge output on, a rectangle that overlaps the filter box gives three
// items (info, left edge, right edge) tagged with a running index. a report gives the box
// x, y and z ranges as three items and clears the box. items are taken into an input
// register and evaluated there combinationally; results wait in a three-entry output
// buffer so the next input item can be held meanwhile. an item without results leaves
// the input register at once; the results of an item leave one at a time on the single
// output port, and an item with results waits until the buffer is empty or its last
// word leaves. the first result is offered once the item has been loaded into the buffer.
module bbox_filter_sweep_edge_emitter_top #(
	parameter int COORD_WIDTH = bbfse_pkg::COORD_WIDTH_DEF,
	parameter int INDEX_WIDTH = bbfse_pkg::INDEX_WIDTH_DEF,
	parameter int BLOCK_WIDTH = bbfse_pkg::BLOCK_WIDTH_DEF,
	parameter int ROW_WIDTH   = bbfse_pkg::ROW_WIDTH_DEF,
	localparam int IN_BITS    = 1 + 6 * COORD_WIDTH + 1 + BLOCK_WIDTH + ROW_WIDTH
	                            + INDEX_WIDTH,
	localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8,
	localparam int OUT_BITS   = INDEX_WIDTH + 2 * COORD_WIDTH + 1 + BLOCK_WIDTH
	                            + ROW_WIDTH + 1,
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input items
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// rect_defined, x_low, x_high, y_low, y_high, z_low, z_high, set_id,
	// block_number, row_number, start_index, zero fill
	input  logic [IN_DATA_W-1:0]              s_axis_tdata,
	// command
	input  logic [bbfse_pkg::CMD_W-1:0]       s_axis_tuser,
	// result items
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// rect_index, low_value, high_value, out_set, out_block, out_row,
	// box_defined, zero fill
	output logic [OUT_DATA_W-1:0]             m_axis_tdata,
	// kind
	output logic [bbfse_pkg::KIND_W-1:0]      m_axis_tuser,
	output logic                              m_axis_tlast,
	// configuration writes
	input  logic                              cfg_we,
	input  logic [bbfse_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [COORD_WIDTH-1:0]            cfg_data
);

	localparam int WORD_W = 1 + bbfse_pkg::KIND_W + OUT_DATA_W;
	localparam logic [COORD_WIDTH-1:0] MOST_NEG = {1'b1, {(COORD_WIDTH-1){1'b0}}};
	localparam logic [COORD_WIDTH-1:0] MOST_POS = {1'b0, {(COORD_WIDTH-1){1'b1}}};

	// ---------------------------------------------------------------- configuration
	logic signed [COORD_WIDTH-1:0] filt_xl_q, filt_xh_q, filt_yl_q, filt_yh_q;
	logic signed [COORD_WIDTH-1:0] filt_zl_q, filt_zh_q;
	logic                          emit_edges_q, three_dims_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_xl_q    <= MOST_NEG;
			filt_xh_q    <= MOST_POS;
			filt_yl_q    <= MOST_NEG;
			filt_yh_q    <= MOST_POS;
			filt_zl_q    <= MOST_NEG;
			filt_zh_q    <= MOST_POS;
			emit_edges_q <= 1'b0;
			three_dims_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				bbfse_pkg::REG_FILTER_X_LOW:  filt_xl_q    <= cfg_data;
				bbfse_pkg::REG_FILTER_X_HIGH: filt_xh_q    <= cfg_data;
				bbfse_pkg::REG_FILTER_Y_LOW:  filt_yl_q    <= cfg_data;
				bbfse_pkg::REG_FILTER_Y_HIGH: filt_yh_q    <= cfg_data;
				bbfse_pkg::REG_FILTER_Z_LOW:  filt_zl_q    <= cfg_data;
				bbfse_pkg::REG_FILTER_Z_HIGH: filt_zh_q    <= cfg_data;
				bbfse_pkg::REG_EMIT_EDGES:    emit_edges_q <= cfg_data[0];
				bbfse_pkg::REG_THREE_DIMS:    three_dims_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- input register
	logic                          valid_s1;
	logic [IN_DATA_W-1:0]          data_s1;
	logic [bbfse_pkg::CMD_W-1:0]   cmd_s1;
	logic                          adv_s1;
	logic                          in_fire;

	assign s_axis_tready = !valid_s1 || adv_s1;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			data_s1 <= s_axis_tdata;
			cmd_s1  <= s_axis_tuser;
		end
	end

	// field unpacking, lowest bits first
	localparam int XL_LSB  = 1;
	localparam int XH_LSB  = XL_LSB + COORD_WIDTH;
	localparam int YL_LSB  = XH_LSB + COORD_WIDTH;
	localparam int YH_LSB  = YL_LSB + COORD_WIDTH;
	localparam int ZL_LSB  = YH_LSB + COORD_WIDTH;
	localparam int ZH_LSB  = ZL_LSB + COORD_WIDTH;
	localparam int SET_LSB = ZH_LSB + COORD_WIDTH;
	localparam int BLK_LSB = SET_LSB + 1;
	localparam int ROW_LSB = BLK_LSB + BLOCK_WIDTH;
	localparam int IDX_LSB = ROW_LSB + ROW_WIDTH;

	logic                          rect_def;
	logic signed [COORD_WIDTH-1:0] xl, xh, yl, yh, zl, zh;
	logic                          set_id;
	logic [BLOCK_WIDTH-1:0]        blk;
	logic [ROW_WIDTH-1:0]          row;
	logic [INDEX_WIDTH-1:0]        start_idx;

	assign rect_def  = data_s1[0];
	assign xl        = data_s1[XL_LSB +: COORD_WIDTH];
	assign xh        = data_s1[XH_LSB +: COORD_WIDTH];
	assign yl        = data_s1[YL_LSB +: COORD_WIDTH];
	assign yh        = data_s1[YH_LSB +: COORD_WIDTH];
	assign zl        = data_s1[ZL_LSB +: COORD_WIDTH];
	assign zh        = data_s1[ZH_LSB +: COORD_WIDTH];
	assign set_id    = data_s1[SET_LSB];
	assign blk       = data_s1[BLK_LSB +: BLOCK_WIDTH];
	assign row       = data_s1[ROW_LSB +: ROW_WIDTH];
	assign start_idx = data_s1[IDX_LSB +: INDEX_WIDTH];

	// ---------------------------------------------------------------- box state
	logic signed [COORD_WIDTH-1:0] box_xl_q, box_xh_q, box_yl_q, box_yh_q;
	logic signed [COORD_WIDTH-1:0] box_zl_q, box_zh_q;
	logic                          box_seen_q;
	logic [INDEX_WIDTH-1:0]        next_idx_q;

	logic signed [COORD_WIDTH-1:0] box_xl_d, box_xh_d, box_yl_d, box_yh_d;
	logic signed [COORD_WIDTH-1:0] box_zl_d, box_zh_d;
	logic                          box_seen_d;
	logic [INDEX_WIDTH-1:0]        next_idx_d;

	// ---------------------------------------------------------------- evaluation
	logic                                        outside;
	logic [bbfse_pkg::LEVEL_W-1:0]               n_res;
	logic [bbfse_pkg::NUM_SLOTS-1:0][WORD_W-1:0] res_words;
	logic signed [COORD_WIDTH-1:0]               rep_zl, rep_zh;

	// pack one result word: tlast, kind, then tdata fields from the lowest bit up
	function automatic logic [WORD_W-1:0] pack_word(
		input logic                         last,
		input bbfse_pkg::kind_t             kind,
		input logic [INDEX_WIDTH-1:0]       idx,
		input logic [COORD_WIDTH-1:0]       lo,
		input logic [COORD_WIDTH-1:0]       hi,
		input logic                         set,
		input logic [BLOCK_WIDTH-1:0]       b,
		input logic [ROW_WIDTH-1:0]         r,
		input logic                         def
	);
		logic [OUT_DATA_W-1:0] d;
		d = OUT_DATA_W'({def, r, b, set, hi, lo, idx});
		return {last, kind, d};
	endfunction

	// overlap test against the filter box, z only in 3-D mode
	always_comb begin
		outside = (xh < filt_xl_q) || (filt_xh_q < xl) ||
		          (yh < filt_yl_q) || (filt_yh_q < yl);
		if (three_dims_q) begin
			outside = outside || (zh < filt_zl_q) || (filt_zh_q < zl);
		end
	end

	// 2-D mode reports the full z span
	assign rep_zl = three_dims_q ? box_zl_q : MOST_NEG;
	assign rep_zh = three_dims_q ? box_zh_q : MOST_POS;

	always_comb begin
		box_xl_d   = box_xl_q;
		box_xh_d   = box_xh_q;
		box_yl_d   = box_yl_q;
		box_yh_d   = box_yh_q;
		box_zl_d   = box_zl_q;
		box_zh_d   = box_zh_q;
		box_seen_d = box_seen_q;
		next_idx_d = next_idx_q;
		n_res      = '0;
		res_words[0] = pack_word(1'b0, bbfse_pkg::KIND_INFO, next_idx_q, yl, yh,
		                         set_id, blk, row, 1'b0);
		res_words[1] = pack_word(1'b0, bbfse_pkg::KIND_LEFT, next_idx_q, xl, '0,
		                         1'b0, '0, '0, 1'b0);
		res_words[2] = pack_word(1'b1, bbfse_pkg::KIND_RIGHT, next_idx_q, xh, '0,
		                         1'b0, '0, '0, 1'b0);
		case (cmd_s1)
			bbfse_pkg::CMD_REPORT: begin
				n_res = bbfse_pkg::LEVEL_W'(3);
				res_words[0] = pack_word(1'b0, bbfse_pkg::KIND_BOX_X, '0, box_xl_q,
				                         box_xh_q, 1'b0, '0, '0, box_seen_q);
				res_words[1] = pack_word(1'b0, bbfse_pkg::KIND_BOX_Y, '0, box_yl_q,
				                         box_yh_q, 1'b0, '0, '0, box_seen_q);
				res_words[2] = pack_word(1'b1, bbfse_pkg::KIND_BOX_Z, '0, rep_zl,
				                         rep_zh, 1'b0, '0, '0, box_seen_q);
				// report clears the box, index is kept
				box_xl_d   = MOST_POS;
				box_xh_d   = MOST_NEG;
				box_yl_d   = MOST_POS;
				box_yh_d   = MOST_NEG;
				box_zl_d   = MOST_POS;
				box_zh_d   = MOST_NEG;
				box_seen_d = 1'b0;
			end
			bbfse_pkg::CMD_LOAD: begin
				next_idx_d = start_idx;
			end
			bbfse_pkg::CMD_RECT: begin
				if (rect_def) begin
					if (xl < box_xl_q) box_xl_d = xl;
					if (box_xh_q < xh) box_xh_d = xh;
					if (yl < box_yl_q) box_yl_d = yl;
					if (box_yh_q < yh) box_yh_d = yh;
					if (three_dims_q) begin
						if (zl < box_zl_q) box_zl_d = zl;
						if (box_zh_q < zh) box_zh_d = zh;
					end
					box_seen_d = 1'b1;
					if (emit_edges_q && !outside) begin
						n_res      = bbfse_pkg::LEVEL_W'(3);
						next_idx_d = next_idx_q + INDEX_WIDTH'(1);
					end
				end
			end
			default: ; // unused command, no effect
		endcase
	end

	// ---------------------------------------------------------------- output buffer
	bbfse_pkg::buf_load_t buf_load;
	bbfse_pkg::buf_stat_t buf_stat;
	logic [WORD_W-1:0]    out_word;

	// items without results pass at once; others wait for room in the buffer
	assign adv_s1        = valid_s1 && ((n_res == '0) || buf_stat.free);
	assign buf_load.push  = adv_s1 && (n_res != '0);
	assign buf_load.count = n_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_xl_q   <= MOST_POS;
			box_xh_q   <= MOST_NEG;
			box_yl_q   <= MOST_POS;
			box_yh_q   <= MOST_NEG;
			box_zl_q   <= MOST_POS;
			box_zh_q   <= MOST_NEG;
			box_seen_q <= 1'b0;
			next_idx_q <= '0;
		end else if (adv_s1) begin
			box_xl_q   <= box_xl_d;
			box_xh_q   <= box_xh_d;
			box_yl_q   <= box_yl_d;
			box_yh_q   <= box_yh_d;
			box_zl_q   <= box_zl_d;
			box_zh_q   <= box_zh_d;
			box_seen_q <= box_seen_d;
			next_idx_q <= next_idx_d;
		end
	end

	bbfse_out_buf #(
		.WORD_W (WORD_W)
	) u_out_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (buf_load),
		.words  (res_words),
		.stat   (buf_stat),
		.valid  (m_axis_tvalid),
		.ready  (m_axis_tready),
		.word   (out_word)
	);

	assign m_axis_tdata = out_word[OUT_DATA_W-1:0];
	assign m_axis_tuser = out_word[OUT_DATA_W +: bbfse_pkg::KIND_W];
	assign m_axis_tlast = out_word[WORD_W-1];

	// ---------------------------------------------------------------- assertions
	logic out_fire;
	assign out_fire = m_axis_tvalid && m_axis_tready;

	// the run of results only ends on a right edge or the z range of a report
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |->
		(m_axis_tuser == bbfse_pkg::KIND_RIGHT || m_axis_tuser == bbfse_pkg::KIND_BOX_Z))
		else $error("tlast on a result that does not end a run");

	// info is always followed by its left edge
	a_info_then_left: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && m_axis_tuser == bbfse_pkg::KIND_INFO) |=>
		(m_axis_tvalid && m_axis_tuser == bbfse_pkg::KIND_LEFT))
		else $error("left edge does not follow rectangle info");

	// a report leaves the box empty
	a_report_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && cmd_s1 == bbfse_pkg::CMD_REPORT) |=> !box_seen_q)
		else $error("box not cleared after report");

	// results are only loaded when the buffer has room
	a_load_room: assert property (@(posedge clk) disable iff (!arst_n)
		buf_load.push |-> buf_stat.free)
		else $error("result buffer overrun");

endmodule

>>> hw/rtl/bbfse_out_buf.sv
module bbfse_out_buf #(
	parameter int WORD_W = 8
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  bbfse_pkg::buf_load_t                            load,
	input  logic [bbfse_pkg::NUM_SLOTS-1:0][WORD_W-1:0]     words,
	output bbfse_pkg::buf_stat_t                            stat,
	output logic                                            valid,
	input  logic                                            ready,
	output logic [WORD_W-1:0]                               word
);

	logic [bbfse_pkg::LEVEL_W-1:0]               level_q;
	logic [bbfse_pkg::NUM_SLOTS-1:0][WORD_W-1:0] words_q;
	logic                                        fire;

	assign valid = (level_q != '0);
	assign fire  = valid && ready;
	assign word  = words_q[0];

	// free when empty or the final pending word leaves this cycle
	assign stat.free   = (level_q == '0) || ((level_q == bbfse_pkg::LEVEL_W'(1)) && ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
		end else if (load.push) begin
			level_q <= load.count;
		end else if (fire) begin
			level_q <= level_q - bbfse_pkg::LEVEL_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load.push) begin
			words_q <= words;
		end else if (fire) begin
			words_q[0] <= words_q[1];
			words_q[1] <= words_q[2];
		end
	end

endmodule
